// ===== rtl/ra61_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, widths and constants of the rotational anisotropy field pipeline.
// Used by every file of the block; depends on nothing.
package ra61_pkg;

  localparam int FRAC_BITS = 16;
  localparam int SPIN_W    = 18;
  localparam int FIELD_W   = 32;
  localparam int K_W       = 24;

  localparam int ROUND     = 1 << (FRAC_BITS - 1);
  localparam int PROD_W    = 2 * SPIN_W;
  localparam int PROJ_W    = PROD_W + 2;
  localparam int CLAMP_W   = PROJ_W - FRAC_BITS;
  localparam int MQ_W      = PROD_W - FRAC_BITS;
  localparam int K5_W      = MQ_W + 3;
  localparam int KP_W      = K_W + MQ_W;
  localparam int KB_W      = K_W + K5_W;
  localparam int EN_W      = KP_W - FRAC_BITS;
  localparam int COEF_W    = 26;
  localparam int TERM_P_W  = COEF_W + SPIN_W;
  localparam int TERM_W    = TERM_P_W - FRAC_BITS;
  localparam int SUM_W     = FIELD_W + 2;

  localparam int APB_AW    = 5;
  localparam int APB_DW    = 32;

  localparam logic signed [SPIN_W-1:0] Q_ONE   = SPIN_W'(1 << FRAC_BITS);
  localparam logic signed [SPIN_W-1:0] C_10_11 = SPIN_W'(((10 << FRAC_BITS) + 5) / 11);
  localparam logic signed [SPIN_W-1:0] C_6_11  = SPIN_W'(((6 << FRAC_BITS) + 5) / 11);
  localparam logic signed [SPIN_W-1:0] C_5_33  = SPIN_W'(((5 << FRAC_BITS) + 16) / 33);
  localparam logic signed [SPIN_W-1:0] C_1_33  = SPIN_W'(((1 << FRAC_BITS) + 16) / 33);

  localparam logic signed [FIELD_W-1:0] F_MAX = {1'b0, {(FIELD_W-1){1'b1}}};
  localparam logic signed [FIELD_W-1:0] F_MIN = {1'b1, {(FIELD_W-1){1'b0}}};

  typedef enum logic [2:0] {
    REG_ENABLE      = 3'd0,
    REG_EASY_AXIS_X = 3'd1,
    REG_EASY_AXIS_Y = 3'd2,
    REG_EASY_AXIS_Z = 3'd3,
    REG_REF_AXIS_X  = 3'd4,
    REG_REF_AXIS_Y  = 3'd5,
    REG_REF_AXIS_Z  = 3'd6,
    REG_ANISO_CONST = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic                     enable;
    logic signed [SPIN_W-1:0] easy_axis_x;
    logic signed [SPIN_W-1:0] easy_axis_y;
    logic signed [SPIN_W-1:0] easy_axis_z;
    logic signed [SPIN_W-1:0] ref_axis_x;
    logic signed [SPIN_W-1:0] ref_axis_y;
    logic signed [SPIN_W-1:0] ref_axis_z;
    logic signed [K_W-1:0]    aniso_const;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    enable:      1'b0,
    easy_axis_x: '0,
    easy_axis_y: '0,
    easy_axis_z: Q_ONE,
    ref_axis_x:  Q_ONE,
    ref_axis_y:  '0,
    ref_axis_z:  '0,
    aniso_const: '0
  };

  typedef struct packed {
    logic signed [SPIN_W-1:0]  spin_x;
    logic signed [SPIN_W-1:0]  spin_y;
    logic signed [SPIN_W-1:0]  spin_z;
    logic signed [FIELD_W-1:0] field_in_x;
    logic signed [FIELD_W-1:0] field_in_y;
    logic signed [FIELD_W-1:0] field_in_z;
    logic                      last_atom;
  } in_t;

  typedef struct packed {
    logic signed [SPIN_W-1:0]  pz;
    logic signed [SPIN_W-1:0]  px;
    logic signed [FIELD_W-1:0] field_in_x;
    logic signed [FIELD_W-1:0] field_in_y;
    logic signed [FIELD_W-1:0] field_in_z;
    logic                      last_atom;
  } proj_t;

  typedef struct packed {
    logic signed [MQ_W-1:0]    a;
    logic signed [MQ_W-1:0]    b;
    logic signed [MQ_W-1:0]    ee;
    logic signed [FIELD_W-1:0] field_in_x;
    logic signed [FIELD_W-1:0] field_in_y;
    logic signed [FIELD_W-1:0] field_in_z;
    logic                      last_atom;
  } poly_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] field_out_x;
    logic signed [FIELD_W-1:0] field_out_y;
    logic signed [FIELD_W-1:0] field_out_z;
    logic signed [FIELD_W-1:0] energy;
    logic                      last_result;
  } out_t;

  function automatic logic signed [SPIN_W-1:0] clamp_one(input logic signed [CLAMP_W-1:0] v);
    logic signed [SPIN_W-1:0] r;
    if (v > Q_ONE) begin
      r = Q_ONE;
    end else if (v < -Q_ONE) begin
      r = -Q_ONE;
    end else begin
      r = v[SPIN_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [FIELD_W-1:0] sat_field(input logic signed [SUM_W-1:0] v);
    logic signed [FIELD_W-1:0] r;
    if (v > F_MAX) begin
      r = F_MAX;
    end else if (v < F_MIN) begin
      r = F_MIN;
    end else begin
      r = v[FIELD_W-1:0];
    end
    return r;
  endfunction

endpackage

// ===== rtl/ra61_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the spin input and the field result.
// Depends on ra61_pkg for the spin and field widths.
interface ra61_in_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ra61_pkg::SPIN_W-1:0]  spin_x;
  logic signed [ra61_pkg::SPIN_W-1:0]  spin_y;
  logic signed [ra61_pkg::SPIN_W-1:0]  spin_z;
  logic signed [ra61_pkg::FIELD_W-1:0] field_in_x;
  logic signed [ra61_pkg::FIELD_W-1:0] field_in_y;
  logic signed [ra61_pkg::FIELD_W-1:0] field_in_z;
  logic                                 last_atom;

  modport source (
    output valid, spin_x, spin_y, spin_z, field_in_x, field_in_y, field_in_z, last_atom,
    input  ready
  );
  modport sink (
    input  valid, spin_x, spin_y, spin_z, field_in_x, field_in_y, field_in_z, last_atom,
    output ready
  );
endinterface

interface ra61_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [ra61_pkg::FIELD_W-1:0] field_out_x;
  logic signed [ra61_pkg::FIELD_W-1:0] field_out_y;
  logic signed [ra61_pkg::FIELD_W-1:0] field_out_z;
  logic signed [ra61_pkg::FIELD_W-1:0] energy;
  logic                                 last_result;

  modport source (
    output valid, field_out_x, field_out_y, field_out_z, energy, last_result,
    input  ready
  );
  modport sink (
    input  valid, field_out_x, field_out_y, field_out_z, energy, last_result,
    output ready
  );
endinterface

// ===== rtl/rotational_anisotropy_6_1_field.sv =====
`timescale 1ns / 1ps
// Top level of the sixth-order rotational anisotropy field term.
// Depends on ra61_pkg, ra61_if, ra61_cfg, ra61_proj, ra61_poly and ra61_field.
//
// The block takes one spin beat per clock cycle while the output keeps up and returns one
// result beat for each, in order. The nine register stages are the axis products, the
// projection sum with round and clamp, four stages of Sz powers, polynomials and their
// products with the projections, the products with the constant, the axis products of
// the field term and the final saturating sum, each holding at most one multiplier deep
// between registers. Every stage carries a valid bit, so bubbles are squeezed out and
// input is still taken while a result waits at the output, until the pipeline fills.
// Write the registers only while the pipeline is empty.
module rotational_anisotropy_6_1_field (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  ra61_in_if.sink                     in_i,
  ra61_out_if.source                  out_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ra61_pkg::APB_AW-1:0] paddr,
  input  logic [ra61_pkg::APB_DW-1:0] pwdata,
  output logic [ra61_pkg::APB_DW-1:0] prdata,
  output logic                        pready
);

  ra61_pkg::cfg_t  cfg;
  ra61_pkg::in_t   in_s;
  ra61_pkg::proj_t proj_s;
  ra61_pkg::poly_t poly_s;
  ra61_pkg::out_t  out_s;
  logic            proj_valid, proj_ready;
  logic            poly_valid, poly_ready;

  assign in_s.spin_x     = in_i.spin_x;
  assign in_s.spin_y     = in_i.spin_y;
  assign in_s.spin_z     = in_i.spin_z;
  assign in_s.field_in_x = in_i.field_in_x;
  assign in_s.field_in_y = in_i.field_in_y;
  assign in_s.field_in_z = in_i.field_in_z;
  assign in_s.last_atom  = in_i.last_atom;

  ra61_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ra61_proj u_proj (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .in_i    (in_s),
    .valid_o (proj_valid),
    .ready_i (proj_ready),
    .proj_o  (proj_s)
  );

  ra61_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (proj_valid),
    .ready_o (proj_ready),
    .proj_i  (proj_s),
    .valid_o (poly_valid),
    .ready_i (poly_ready),
    .poly_o  (poly_s)
  );

  ra61_field u_field (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (poly_valid),
    .ready_o (poly_ready),
    .poly_i  (poly_s),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .out_o   (out_s)
  );

  assign out_o.field_out_x = out_s.field_out_x;
  assign out_o.field_out_y = out_s.field_out_y;
  assign out_o.field_out_z = out_s.field_out_z;
  assign out_o.energy      = out_s.energy;
  assign out_o.last_result = out_s.last_result;

endmodule

// ===== rtl/ra61_cfg.sv =====
`timescale 1ns / 1ps
// APB register bank holding the enable, the two axes and the anisotropy constant.
// Depends on ra61_pkg.
module ra61_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ra61_pkg::APB_AW-1:0]   paddr,
  input  logic [ra61_pkg::APB_DW-1:0]   pwdata,
  output logic [ra61_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output ra61_pkg::cfg_t                cfg_o
);

  ra61_pkg::cfg_t     cfg_q, cfg_d;
  ra61_pkg::reg_idx_e idx;
  logic               wr;

  assign idx    = ra61_pkg::reg_idx_e'(paddr[ra61_pkg::APB_AW-1:2]);
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr) begin
      unique case (idx)
        ra61_pkg::REG_ENABLE:      cfg_d.enable      = pwdata[0];
        ra61_pkg::REG_EASY_AXIS_X: cfg_d.easy_axis_x = pwdata[ra61_pkg::SPIN_W-1:0];
        ra61_pkg::REG_EASY_AXIS_Y: cfg_d.easy_axis_y = pwdata[ra61_pkg::SPIN_W-1:0];
        ra61_pkg::REG_EASY_AXIS_Z: cfg_d.easy_axis_z = pwdata[ra61_pkg::SPIN_W-1:0];
        ra61_pkg::REG_REF_AXIS_X:  cfg_d.ref_axis_x  = pwdata[ra61_pkg::SPIN_W-1:0];
        ra61_pkg::REG_REF_AXIS_Y:  cfg_d.ref_axis_y  = pwdata[ra61_pkg::SPIN_W-1:0];
        ra61_pkg::REG_REF_AXIS_Z:  cfg_d.ref_axis_z  = pwdata[ra61_pkg::SPIN_W-1:0];
        ra61_pkg::REG_ANISO_CONST: cfg_d.aniso_const = pwdata[ra61_pkg::K_W-1:0];
        default:                   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      ra61_pkg::REG_ENABLE:      prdata[0] = cfg_q.enable;
      ra61_pkg::REG_EASY_AXIS_X: prdata[ra61_pkg::SPIN_W-1:0] = cfg_q.easy_axis_x;
      ra61_pkg::REG_EASY_AXIS_Y: prdata[ra61_pkg::SPIN_W-1:0] = cfg_q.easy_axis_y;
      ra61_pkg::REG_EASY_AXIS_Z: prdata[ra61_pkg::SPIN_W-1:0] = cfg_q.easy_axis_z;
      ra61_pkg::REG_REF_AXIS_X:  prdata[ra61_pkg::SPIN_W-1:0] = cfg_q.ref_axis_x;
      ra61_pkg::REG_REF_AXIS_Y:  prdata[ra61_pkg::SPIN_W-1:0] = cfg_q.ref_axis_y;
      ra61_pkg::REG_REF_AXIS_Z:  prdata[ra61_pkg::SPIN_W-1:0] = cfg_q.ref_axis_z;
      ra61_pkg::REG_ANISO_CONST: prdata[ra61_pkg::K_W-1:0]    = cfg_q.aniso_const;
      default:                   prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= ra61_pkg::CFG_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/ra61_proj.sv =====
`timescale 1ns / 1ps
// Two pipeline stages projecting the spin onto the easy and reference axes.
// Depends on ra61_pkg.
module ra61_proj (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ra61_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  ra61_pkg::in_t   in_i,
  output logic            valid_o,
  input  logic            ready_i,
  output ra61_pkg::proj_t proj_o
);

  localparam int NS = 2;

  typedef struct packed {
    logic signed [ra61_pkg::PROD_W-1:0] ex;
    logic signed [ra61_pkg::PROD_W-1:0] ey;
    logic signed [ra61_pkg::PROD_W-1:0] ez;
    logic signed [ra61_pkg::PROD_W-1:0] rx;
    logic signed [ra61_pkg::PROD_W-1:0] ry;
    logic signed [ra61_pkg::PROD_W-1:0] rz;
    ra61_pkg::in_t                      item;
  } s1_t;

  logic [NS-1:0]   v_q, v_d, adv;
  s1_t             s1_q, s1_d;
  ra61_pkg::proj_t s2_q, s2_d;

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || ready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
    v_d = v_q;
    if (adv[0]) begin
      v_d[0] = valid_i;
    end
    for (int i = 1; i < NS; i++) begin
      if (adv[i]) begin
        v_d[i] = v_q[i-1];
      end
    end
  end

  assign ready_o = adv[0];
  assign valid_o = v_q[NS-1];
  assign proj_o  = s2_q;

  always_comb begin
    s1_d.ex   = in_i.spin_x * cfg_i.easy_axis_x;
    s1_d.ey   = in_i.spin_y * cfg_i.easy_axis_y;
    s1_d.ez   = in_i.spin_z * cfg_i.easy_axis_z;
    s1_d.rx   = in_i.spin_x * cfg_i.ref_axis_x;
    s1_d.ry   = in_i.spin_y * cfg_i.ref_axis_y;
    s1_d.rz   = in_i.spin_z * cfg_i.ref_axis_z;
    s1_d.item = in_i;
  end

  always_comb begin
    logic signed [ra61_pkg::PROJ_W-1:0] sum_z;
    logic signed [ra61_pkg::PROJ_W-1:0] sum_x;
    sum_z = s1_q.ex + s1_q.ey + s1_q.ez + ra61_pkg::ROUND;
    sum_x = s1_q.rx + s1_q.ry + s1_q.rz + ra61_pkg::ROUND;
    s2_d.pz         = ra61_pkg::clamp_one(sum_z[ra61_pkg::PROJ_W-1:ra61_pkg::FRAC_BITS]);
    s2_d.px         = ra61_pkg::clamp_one(sum_x[ra61_pkg::PROJ_W-1:ra61_pkg::FRAC_BITS]);
    s2_d.field_in_x = s1_q.item.field_in_x;
    s2_d.field_in_y = s1_q.item.field_in_y;
    s2_d.field_in_z = s1_q.item.field_in_z;
    s2_d.last_atom  = s1_q.item.last_atom;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s1_q <= s1_d;
    end
    if (adv[1]) begin
      s2_q <= s2_d;
    end
  end

  a_proj_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (s2_q.pz <= ra61_pkg::Q_ONE) && (s2_q.pz >= -ra61_pkg::Q_ONE) &&
               (s2_q.px <= ra61_pkg::Q_ONE) && (s2_q.px >= -ra61_pkg::Q_ONE))
    else $error("projection left the unit range");

endmodule

// ===== rtl/ra61_poly.sv =====
`timescale 1ns / 1ps
// Four pipeline stages forming the angular polynomials in Sz and their products.
// Depends on ra61_pkg.
module ra61_poly (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  ra61_pkg::proj_t proj_i,
  output logic            valid_o,
  input  logic            ready_i,
  output ra61_pkg::poly_t poly_o
);

  localparam int NS = 4;

  typedef struct packed {
    logic signed [ra61_pkg::SPIN_W-1:0] z2;
    logic signed [ra61_pkg::SPIN_W-1:0] pxz;
    ra61_pkg::proj_t                    pr;
  } s3_t;

  typedef struct packed {
    logic signed [ra61_pkg::SPIN_W-1:0] z4;
    logic signed [ra61_pkg::SPIN_W-1:0] t10;
    logic signed [ra61_pkg::SPIN_W-1:0] t6;
    logic signed [ra61_pkg::SPIN_W-1:0] pxz;
    ra61_pkg::proj_t                    pr;
  } s4_t;

  typedef struct packed {
    logic signed [ra61_pkg::SPIN_W-1:0] p;
    logic signed [ra61_pkg::SPIN_W-1:0] q;
    logic signed [ra61_pkg::SPIN_W-1:0] pxz;
    ra61_pkg::proj_t                    pr;
  } s5_t;

  logic [NS-1:0]   v_q, v_d, adv;
  s3_t             s3_q, s3_d;
  s4_t             s4_q, s4_d;
  s5_t             s5_q, s5_d;
  ra61_pkg::poly_t s6_q, s6_d;

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || ready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
    v_d = v_q;
    if (adv[0]) begin
      v_d[0] = valid_i;
    end
    for (int i = 1; i < NS; i++) begin
      if (adv[i]) begin
        v_d[i] = v_q[i-1];
      end
    end
  end

  assign ready_o = adv[0];
  assign valid_o = v_q[NS-1];
  assign poly_o  = s6_q;

  always_comb begin
    logic signed [ra61_pkg::PROD_W-1:0] zz;
    logic signed [ra61_pkg::PROD_W-1:0] xz;
    zz = proj_i.pz * proj_i.pz + ra61_pkg::ROUND;
    xz = proj_i.px * proj_i.pz + ra61_pkg::ROUND;
    s3_d.z2  = zz[ra61_pkg::FRAC_BITS+ra61_pkg::SPIN_W-1:ra61_pkg::FRAC_BITS];
    s3_d.pxz = xz[ra61_pkg::FRAC_BITS+ra61_pkg::SPIN_W-1:ra61_pkg::FRAC_BITS];
    s3_d.pr  = proj_i;
  end

  always_comb begin
    logic signed [ra61_pkg::PROD_W-1:0] m4;
    logic signed [ra61_pkg::PROD_W-1:0] m10;
    logic signed [ra61_pkg::PROD_W-1:0] m6;
    m4  = s3_q.z2 * s3_q.z2 + ra61_pkg::ROUND;
    m10 = ra61_pkg::C_10_11 * s3_q.z2 + ra61_pkg::ROUND;
    m6  = ra61_pkg::C_6_11 * s3_q.z2 + ra61_pkg::ROUND;
    s4_d.z4  = m4[ra61_pkg::FRAC_BITS+ra61_pkg::SPIN_W-1:ra61_pkg::FRAC_BITS];
    s4_d.t10 = m10[ra61_pkg::FRAC_BITS+ra61_pkg::SPIN_W-1:ra61_pkg::FRAC_BITS];
    s4_d.t6  = m6[ra61_pkg::FRAC_BITS+ra61_pkg::SPIN_W-1:ra61_pkg::FRAC_BITS];
    s4_d.pxz = s3_q.pxz;
    s4_d.pr  = s3_q.pr;
  end

  always_comb begin
    s5_d.p   = s4_q.z4 - s4_q.t10 + ra61_pkg::C_5_33;
    s5_d.q   = s4_q.z4 - s4_q.t6 + ra61_pkg::C_1_33;
    s5_d.pxz = s4_q.pxz;
    s5_d.pr  = s4_q.pr;
  end

  always_comb begin
    logic signed [ra61_pkg::PROD_W-1:0] ma;
    logic signed [ra61_pkg::PROD_W-1:0] mb;
    logic signed [ra61_pkg::PROD_W-1:0] me;
    ma = s5_q.pr.pz * s5_q.p + ra61_pkg::ROUND;
    mb = s5_q.pr.px * s5_q.q + ra61_pkg::ROUND;
    me = s5_q.pxz * s5_q.p + ra61_pkg::ROUND;
    s6_d.a          = ma[ra61_pkg::PROD_W-1:ra61_pkg::FRAC_BITS];
    s6_d.b          = mb[ra61_pkg::PROD_W-1:ra61_pkg::FRAC_BITS];
    s6_d.ee         = me[ra61_pkg::PROD_W-1:ra61_pkg::FRAC_BITS];
    s6_d.field_in_x = s5_q.pr.field_in_x;
    s6_d.field_in_y = s5_q.pr.field_in_y;
    s6_d.field_in_z = s5_q.pr.field_in_z;
    s6_d.last_atom  = s5_q.pr.last_atom;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s3_q <= s3_d;
    end
    if (adv[1]) begin
      s4_q <= s4_d;
    end
    if (adv[2]) begin
      s5_q <= s5_d;
    end
    if (adv[3]) begin
      s6_q <= s6_d;
    end
  end

  a_z2_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] |-> (s3_q.z2 >= 0) && (s3_q.z2 <= ra61_pkg::Q_ONE))
    else $error("Sz squared outside the unit range");

  a_z4_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[1] |-> (s4_q.z4 >= 0) && (s4_q.z4 <= ra61_pkg::Q_ONE))
    else $error("Sz to the fourth outside the unit range");

endmodule

// ===== rtl/ra61_field.sv =====
`timescale 1ns / 1ps
// Three pipeline stages scaling by the anisotropy constant and, when enabled,
// adding the field. Depends on ra61_pkg; the last stage is the output register.
module ra61_field (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ra61_pkg::cfg_t  cfg_i,
  input  logic            valid_i,
  output logic            ready_o,
  input  ra61_pkg::poly_t poly_i,
  output logic            valid_o,
  input  logic            ready_i,
  output ra61_pkg::out_t  out_o
);

  localparam int NS = 3;

  typedef struct packed {
    logic signed [ra61_pkg::COEF_W-1:0]  xc;
    logic signed [ra61_pkg::COEF_W-1:0]  zc;
    logic signed [ra61_pkg::EN_W-1:0]    en;
    logic signed [ra61_pkg::FIELD_W-1:0] field_in_x;
    logic signed [ra61_pkg::FIELD_W-1:0] field_in_y;
    logic signed [ra61_pkg::FIELD_W-1:0] field_in_z;
    logic                                last_atom;
  } s7_t;

  typedef struct packed {
    logic signed [ra61_pkg::TERM_W-1:0]  tzx;
    logic signed [ra61_pkg::TERM_W-1:0]  tzy;
    logic signed [ra61_pkg::TERM_W-1:0]  tzz;
    logic signed [ra61_pkg::TERM_W-1:0]  txx;
    logic signed [ra61_pkg::TERM_W-1:0]  txy;
    logic signed [ra61_pkg::TERM_W-1:0]  txz;
    logic signed [ra61_pkg::FIELD_W-1:0] energy;
    logic signed [ra61_pkg::FIELD_W-1:0] field_in_x;
    logic signed [ra61_pkg::FIELD_W-1:0] field_in_y;
    logic signed [ra61_pkg::FIELD_W-1:0] field_in_z;
    logic                                last_atom;
  } s8_t;

  logic [NS-1:0]  v_q, v_d, adv;
  s7_t            s7_q, s7_d;
  s8_t            s8_q, s8_d;
  ra61_pkg::out_t s9_q, s9_d;

  always_comb begin
    adv[NS-1] = !v_q[NS-1] || ready_i;
    for (int i = NS - 2; i >= 0; i--) begin
      adv[i] = !v_q[i] || adv[i+1];
    end
    v_d = v_q;
    if (adv[0]) begin
      v_d[0] = valid_i;
    end
    for (int i = 1; i < NS; i++) begin
      if (adv[i]) begin
        v_d[i] = v_q[i-1];
      end
    end
  end

  assign ready_o = adv[0];
  assign valid_o = v_q[NS-1];
  assign out_o   = s9_q;

  always_comb begin
    logic signed [ra61_pkg::K5_W-1:0] b_ext;
    logic signed [ra61_pkg::K5_W-1:0] b5;
    logic signed [ra61_pkg::KP_W-1:0] mx;
    logic signed [ra61_pkg::KB_W-1:0] mz;
    logic signed [ra61_pkg::KP_W-1:0] me;
    b_ext = ra61_pkg::K5_W'(poly_i.b);
    b5    = (b_ext <<< 2) + b_ext;
    mx    = cfg_i.aniso_const * poly_i.a + ra61_pkg::ROUND;
    mz    = cfg_i.aniso_const * b5 + ra61_pkg::ROUND;
    me    = cfg_i.aniso_const * poly_i.ee + ra61_pkg::ROUND;
    s7_d.xc = mx[ra61_pkg::FRAC_BITS+ra61_pkg::COEF_W-1:ra61_pkg::FRAC_BITS];
    s7_d.zc = mz[ra61_pkg::FRAC_BITS+ra61_pkg::COEF_W-1:ra61_pkg::FRAC_BITS];
    s7_d.en = me[ra61_pkg::KP_W-1:ra61_pkg::FRAC_BITS];
    s7_d.field_in_x = poly_i.field_in_x;
    s7_d.field_in_y = poly_i.field_in_y;
    s7_d.field_in_z = poly_i.field_in_z;
    s7_d.last_atom  = poly_i.last_atom;
  end

  always_comb begin
    logic signed [ra61_pkg::TERM_P_W-1:0] pzx, pzy, pzz, pxx, pxy, pxz;
    logic signed [ra61_pkg::FIELD_W-1:0]  en_ext;
    pzx = s7_q.zc * cfg_i.easy_axis_x + ra61_pkg::ROUND;
    pzy = s7_q.zc * cfg_i.easy_axis_y + ra61_pkg::ROUND;
    pzz = s7_q.zc * cfg_i.easy_axis_z + ra61_pkg::ROUND;
    pxx = s7_q.xc * cfg_i.ref_axis_x + ra61_pkg::ROUND;
    pxy = s7_q.xc * cfg_i.ref_axis_y + ra61_pkg::ROUND;
    pxz = s7_q.xc * cfg_i.ref_axis_z + ra61_pkg::ROUND;
    en_ext = ra61_pkg::FIELD_W'(s7_q.en);
    s8_d.tzx = pzx[ra61_pkg::TERM_P_W-1:ra61_pkg::FRAC_BITS];
    s8_d.tzy = pzy[ra61_pkg::TERM_P_W-1:ra61_pkg::FRAC_BITS];
    s8_d.tzz = pzz[ra61_pkg::TERM_P_W-1:ra61_pkg::FRAC_BITS];
    s8_d.txx = pxx[ra61_pkg::TERM_P_W-1:ra61_pkg::FRAC_BITS];
    s8_d.txy = pxy[ra61_pkg::TERM_P_W-1:ra61_pkg::FRAC_BITS];
    s8_d.txz = pxz[ra61_pkg::TERM_P_W-1:ra61_pkg::FRAC_BITS];
    s8_d.energy     = -en_ext;
    s8_d.field_in_x = s7_q.field_in_x;
    s8_d.field_in_y = s7_q.field_in_y;
    s8_d.field_in_z = s7_q.field_in_z;
    s8_d.last_atom  = s7_q.last_atom;
  end

  always_comb begin
    logic signed [ra61_pkg::SUM_W-1:0] sx, sy, sz;
    sx = s8_q.field_in_x + s8_q.tzx + s8_q.txx;
    sy = s8_q.field_in_y + s8_q.tzy + s8_q.txy;
    sz = s8_q.field_in_z + s8_q.tzz + s8_q.txz;
    if (cfg_i.enable) begin
      s9_d.field_out_x = ra61_pkg::sat_field(sx);
      s9_d.field_out_y = ra61_pkg::sat_field(sy);
      s9_d.field_out_z = ra61_pkg::sat_field(sz);
    end else begin
      s9_d.field_out_x = s8_q.field_in_x;
      s9_d.field_out_y = s8_q.field_in_y;
      s9_d.field_out_z = s8_q.field_in_z;
    end
    s9_d.energy      = s8_q.energy;
    s9_d.last_result = s8_q.last_atom;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      s7_q <= s7_d;
    end
    if (adv[1]) begin
      s8_q <= s8_d;
    end
    if (adv[2]) begin
      s9_q <= s9_d;
    end
  end

  a_stall_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[0] && !adv[0] |=> v_q[0] && $stable(s7_q))
    else $error("stalled coefficient stage lost or changed its beat");

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for rotational_anisotropy_6_1_field: directed and random spin beats
// under random idling, with an in-bench predictor and scoreboard. Depends on ra61_pkg and ra61_if.
module testbench;
  import ra61_pkg::*;

  localparam int LIMIT_CYCLES = 200000;
  localparam int DRAIN_CYCLES = 12;
  localparam int PHASES       = 9;
  localparam int PHASE_ITEMS  = 200;
  localparam int LONG_HOLD    = 120;
  localparam int AXIS_ONE     = 1 << FRAC_BITS;

  class field_scoreboard;
    cfg_t cfg;
    out_t pending_fields[$];
    int   mismatches;

    function new();
      cfg = CFG_RESET;
      mismatches = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [APB_DW-1:0] v);
      case (idx)
        REG_ENABLE:      cfg.enable      = v[0];
        REG_EASY_AXIS_X: cfg.easy_axis_x = v[SPIN_W-1:0];
        REG_EASY_AXIS_Y: cfg.easy_axis_y = v[SPIN_W-1:0];
        REG_EASY_AXIS_Z: cfg.easy_axis_z = v[SPIN_W-1:0];
        REG_REF_AXIS_X:  cfg.ref_axis_x  = v[SPIN_W-1:0];
        REG_REF_AXIS_Y:  cfg.ref_axis_y  = v[SPIN_W-1:0];
        REG_REF_AXIS_Z:  cfg.ref_axis_z  = v[SPIN_W-1:0];
        REG_ANISO_CONST: cfg.aniso_const = v[K_W-1:0];
        default: ;
      endcase
    endfunction

    function longint round_mul(longint a, longint b);
      return (a * b + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function longint limit(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    function logic signed [FIELD_W-1:0] sat32(longint v);
      return FIELD_W'(limit(v, -(longint'(1) <<< (FIELD_W - 1)),
                            (longint'(1) <<< (FIELD_W - 1)) - 1));
    endfunction

    function out_t field_term(in_t s);
      longint one, c10, c6, c5, c1;
      longint sx, sy, sz, ex, ey, ez, rx, ry, rz, k;
      longint pz, px, z2, z4, p, q, xc, zc;
      longint ox, oy, oz;
      out_t r;
      one = longint'(1) <<< FRAC_BITS;
      c10 = ((longint'(10) <<< FRAC_BITS) + 5) / 11;
      c6  = ((longint'(6) <<< FRAC_BITS) + 5) / 11;
      c5  = ((longint'(5) <<< FRAC_BITS) + 16) / 33;
      c1  = ((longint'(1) <<< FRAC_BITS) + 16) / 33;
      sx = s.spin_x;
      sy = s.spin_y;
      sz = s.spin_z;
      ex = cfg.easy_axis_x;
      ey = cfg.easy_axis_y;
      ez = cfg.easy_axis_z;
      rx = cfg.ref_axis_x;
      ry = cfg.ref_axis_y;
      rz = cfg.ref_axis_z;
      k  = cfg.aniso_const;
      pz = limit((sx * ex + sy * ey + sz * ez + (longint'(1) <<< (FRAC_BITS - 1)))
                 >>> FRAC_BITS, -one, one);
      px = limit((sx * rx + sy * ry + sz * rz + (longint'(1) <<< (FRAC_BITS - 1)))
                 >>> FRAC_BITS, -one, one);
      z2 = round_mul(pz, pz);
      z4 = round_mul(z2, z2);
      p  = z4 - round_mul(c10, z2) + c5;
      q  = z4 - round_mul(c6, z2) + c1;
      xc = round_mul(k, round_mul(pz, p));
      zc = round_mul(k, 5 * round_mul(px, q));
      ox = s.field_in_x;
      oy = s.field_in_y;
      oz = s.field_in_z;
      if (cfg.enable) begin
        ox = ox + round_mul(zc, ex) + round_mul(xc, rx);
        oy = oy + round_mul(zc, ey) + round_mul(xc, ry);
        oz = oz + round_mul(zc, ez) + round_mul(xc, rz);
      end
      r.field_out_x = sat32(ox);
      r.field_out_y = sat32(oy);
      r.field_out_z = sat32(oz);
      r.energy      = sat32(-round_mul(k, round_mul(round_mul(px, pz), p)));
      r.last_result = s.last_atom;
      return r;
    endfunction

    function void note_spin(in_t s);
      pending_fields.push_back(field_term(s));
    endfunction

    task report(string what, logic [FIELD_W-1:0] got, logic [FIELD_W-1:0] want);
      $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (pending_fields.size() == 0) begin
        report("result beat with nothing outstanding", got.energy, '0);
      end else begin
        want = pending_fields.pop_front();
        if (got.field_out_x !== want.field_out_x) begin
          report("field_out_x", got.field_out_x, want.field_out_x);
        end
        if (got.field_out_y !== want.field_out_y) begin
          report("field_out_y", got.field_out_y, want.field_out_y);
        end
        if (got.field_out_z !== want.field_out_z) begin
          report("field_out_z", got.field_out_z, want.field_out_z);
        end
        if (got.energy !== want.energy) begin
          report("energy", got.energy, want.energy);
        end
        if (got.last_result !== want.last_result) begin
          report("last_result", got.last_result, want.last_result);
        end
      end
    endtask
  endclass

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  ra61_in_if  spin_ch ();
  ra61_out_if field_ch ();

  field_scoreboard fsb = new();
  int unsigned     cycle_count = 0;
  bit              src_gaps_on = 1'b0;
  bit              snk_stalls_on = 1'b0;
  int              hold_request = 0;

  rotational_anisotropy_6_1_field uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (spin_ch),
    .out_o   (field_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (spin_ch.valid && spin_ch.ready) begin
        fsb.note_spin('{spin_x: spin_ch.spin_x, spin_y: spin_ch.spin_y,
                        spin_z: spin_ch.spin_z, field_in_x: spin_ch.field_in_x,
                        field_in_y: spin_ch.field_in_y, field_in_z: spin_ch.field_in_z,
                        last_atom: spin_ch.last_atom});
      end
      if (field_ch.valid && field_ch.ready) begin
        fsb.check_result('{field_out_x: field_ch.field_out_x,
                           field_out_y: field_ch.field_out_y,
                           field_out_z: field_ch.field_out_z,
                           energy: field_ch.energy,
                           last_result: field_ch.last_result});
      end
    end
  end

  // Result side: a random stall before each beat when stalls are on, and a long hold-off on request.
  initial begin
    int n;
    field_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      n = snk_stalls_on ? $urandom_range(0, 6) : 0;
      if (hold_request != 0) begin
        n = hold_request;
        hold_request = 0;
      end
      if (n > 0) begin
        field_ch.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      field_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!field_ch.valid);
    end
  end

  task automatic apb_write(reg_idx_e idx, logic [APB_DW-1:0] data);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    fsb.set_reg(idx, data);
  endtask

  task automatic write_config(cfg_t c);
    apb_write(REG_ENABLE, APB_DW'(c.enable));
    apb_write(REG_EASY_AXIS_X, APB_DW'(c.easy_axis_x));
    apb_write(REG_EASY_AXIS_Y, APB_DW'(c.easy_axis_y));
    apb_write(REG_EASY_AXIS_Z, APB_DW'(c.easy_axis_z));
    apb_write(REG_REF_AXIS_X, APB_DW'(c.ref_axis_x));
    apb_write(REG_REF_AXIS_Y, APB_DW'(c.ref_axis_y));
    apb_write(REG_REF_AXIS_Z, APB_DW'(c.ref_axis_z));
    apb_write(REG_ANISO_CONST, APB_DW'(c.aniso_const));
  endtask

  task automatic send_spin(in_t s);
    int gap;
    gap = src_gaps_on ? $urandom_range(0, 6) : 0;
    if (gap > 0) begin
      spin_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    spin_ch.valid      <= 1'b1;
    spin_ch.spin_x     <= s.spin_x;
    spin_ch.spin_y     <= s.spin_y;
    spin_ch.spin_z     <= s.spin_z;
    spin_ch.field_in_x <= s.field_in_x;
    spin_ch.field_in_y <= s.field_in_y;
    spin_ch.field_in_z <= s.field_in_z;
    spin_ch.last_atom  <= s.last_atom;
    do @(posedge clk_i); while (!spin_ch.ready);
  endtask

  task automatic drain();
    spin_ch.valid <= 1'b0;
    do @(posedge clk_i); while (fsb.pending_fields.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic in_t make_spin(int x, int y, int z, logic signed [FIELD_W-1:0] f,
                                    logic last);
    in_t s;
    s.spin_x     = SPIN_W'(x);
    s.spin_y     = SPIN_W'(y);
    s.spin_z     = SPIN_W'(z);
    s.field_in_x = f;
    s.field_in_y = f;
    s.field_in_z = f;
    s.last_atom  = last;
    return s;
  endfunction

  function automatic logic signed [SPIN_W-1:0] rand_comp();
    if ($urandom_range(0, 7) == 0) begin
      return SPIN_W'($urandom_range(0, (1 << SPIN_W) - 1));
    end
    return SPIN_W'(int'($urandom_range(0, 2 * AXIS_ONE)) - AXIS_ONE);
  endfunction

  function automatic logic signed [FIELD_W-1:0] rand_field();
    case ($urandom_range(0, 5))
      0: return F_MAX - FIELD_W'($urandom_range(0, 1 << 20));
      1: return F_MIN + FIELD_W'($urandom_range(0, 1 << 20));
      default: return FIELD_W'($urandom());
    endcase
  endfunction

  function automatic logic signed [SPIN_W-1:0] rand_axis(int pick);
    case (pick)
      0: return SPIN_W'(AXIS_ONE);
      1: return SPIN_W'(-AXIS_ONE);
      2: return '0;
      default: return SPIN_W'(int'($urandom_range(0, 2 * AXIS_ONE)) - AXIS_ONE);
    endcase
  endfunction

  initial begin
    cfg_t c;
    in_t  s;
    int   sel;
    rst_ni             <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;
    spin_ch.valid      <= 1'b0;
    spin_ch.spin_x     <= '0;
    spin_ch.spin_y     <= '0;
    spin_ch.spin_z     <= '0;
    spin_ch.field_in_x <= '0;
    spin_ch.field_in_y <= '0;
    spin_ch.field_in_z <= '0;
    spin_ch.last_atom  <= 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: the block passes the field through and k is zero.
    send_spin(make_spin(0, 0, AXIS_ONE, 32'sd12345, 1'b0));
    send_spin(make_spin(AXIS_ONE, 0, 0, F_MAX, 1'b1));
    drain();

    c = CFG_RESET;
    c.enable      = 1'b1;
    c.aniso_const = {1'b0, {(K_W-1){1'b1}}};
    write_config(c);
    for (int pass = 0; pass < 2; pass++) begin
      send_spin(make_spin(0, 0, AXIS_ONE, '0, 1'b0));
      send_spin(make_spin(0, 0, -AXIS_ONE, '0, 1'b0));
      send_spin(make_spin(AXIS_ONE, 0, 0, '0, 1'b0));
      send_spin(make_spin(46341, 0, 46341, '0, 1'b0));
      send_spin(make_spin(-46341, 0, 30000, '0, 1'b0));
      send_spin(make_spin(0, 0, 0, '0, 1'b1));
      send_spin(make_spin(-(1 << (SPIN_W-1)), -(1 << (SPIN_W-1)), -(1 << (SPIN_W-1)),
                          F_MIN, 1'b1));
      send_spin(make_spin((1 << (SPIN_W-1)) - 1, (1 << (SPIN_W-1)) - 1,
                          (1 << (SPIN_W-1)) - 1, F_MAX, 1'b0));
      send_spin(make_spin(40000, 0, 50000, F_MAX, 1'b0));
      send_spin(make_spin(-40000, 0, -50000, F_MIN, 1'b0));
      drain();
      c.aniso_const = {1'b1, {(K_W-1){1'b0}}};
      write_config(c);
    end
    c.enable = 1'b0;
    write_config(c);
    send_spin(make_spin(40000, 0, 50000, F_MAX, 1'b1));
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      for (int r = 0; r < 6; r++) begin
        sel = (ph == 1) ? 0 : ((ph == 3) ? 1 : $urandom_range(0, 7));
        case (r)
          0: c.easy_axis_x = rand_axis(sel);
          1: c.easy_axis_y = rand_axis(sel);
          2: c.easy_axis_z = rand_axis(sel);
          3: c.ref_axis_x  = rand_axis(sel);
          4: c.ref_axis_y  = rand_axis(sel);
          default: c.ref_axis_z = rand_axis(sel);
        endcase
      end
      c.enable = (ph == 2) ? 1'b0 : (ph < 2 ? 1'b1 : ($urandom_range(0, 3) != 0));
      if (ph == 1) begin
        c.aniso_const = {1'b0, {(K_W-1){1'b1}}};
      end else if (ph == 3) begin
        c.aniso_const = {1'b1, {(K_W-1){1'b0}}};
      end else begin
        c.aniso_const = K_W'($urandom());
      end
      write_config(c);
      src_gaps_on   = (ph >= 2) && ($urandom_range(0, 3) != 0);
      snk_stalls_on = (ph >= 2) && ($urandom_range(0, 3) != 0);
      if (ph == 1) begin
        hold_request = LONG_HOLD;
      end
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        s.spin_x     = rand_comp();
        s.spin_y     = rand_comp();
        s.spin_z     = rand_comp();
        s.field_in_x = rand_field();
        s.field_in_y = rand_field();
        s.field_in_z = rand_field();
        s.last_atom  = ($urandom_range(0, 15) == 0) || (i == PHASE_ITEMS - 1);
        send_spin(s);
      end
      drain();
    end

    if (fsb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
